FILE: rtl/head_angle_to_pointer_mapper_top_assert.svh
// Assertion macros used by the checker file.
`ifndef HEAD_ANGLE_TO_POINTER_MAPPER_TOP_ASSERT_SVH
`define HEAD_ANGLE_TO_POINTER_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HAPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hapm_pkg.sv
package hapm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 50;
  localparam int SUM_W     = 51;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ABS_PER_PIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ABS_PER_PIX = 2'd2;

  localparam logic [3:0] WS_BOUND_L = 4'd0;
  localparam logic [3:0] WS_BOUND_B = 4'd3;
  localparam logic [3:0] WS_EDGE_HL = 4'd4;
  localparam logic [3:0] WS_EDGE_HR = 4'd5;
  localparam logic [3:0] WS_EDGE_VT = 4'd6;
  localparam logic [3:0] WS_EDGE_VB = 4'd7;
  localparam logic [3:0] WS_SLOPE_X = 4'd8;
  localparam logic [3:0] WS_SLOPE_Y = 4'd9;
  localparam logic [3:0] WS_PAD_L   = 4'd10;
  localparam logic [3:0] WS_PAD_B   = 4'd13;

  typedef enum logic [1:0] {
    MODE_INTERP,
    MODE_PAD_ADD,
    MODE_PAD_SUB
  } axis_mode_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;        // table write request accepted
    logic start;     // sample request accepted
    logic next;      // advance scan index
    logic hit;       // current entry contains the angles
    logic fall;      // point index at remembered display
    logic decide;    // pick fallback axis modes
    logic mul;       // capture product for selected axis
    logic load_x;    // saturate and hold x
    logic load_out;  // saturate y and fill output register
    logic axis_y;    // axis select for mul and add
  } hapm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic n_zero;
    logic out_free;
  } hapm_sts_t;

  function automatic logic [15:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic [15:0] r;
    if (v[SUM_W-1]) begin
      r = 16'd0;
    end else if (|v[SUM_W-2:32]) begin
      r = POS_MAX;
    end else begin
      r = v[31:16];
    end
    return r;
  endfunction

endpackage

FILE: rtl/head_angle_to_pointer_mapper_top.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | func, yaw, pitch, entry_index, word_select,
//         |           |                     | word_value
// out_    | output    | out_valid/out_ready | pointer_x, pointer_y, on_screen, screen_used
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// A table write is taken in the idle state; in_ready stays high.
// A sample scans the displays from index 0 and stops at the first match; when none of the n
// scanned displays matches, it falls back to the remembered display. One table entry is
// compared per cycle, then one shared 33x17 multiplier serves x and then y.
// in_ready returns with out_valid, as the result enters the output register; a stalled output
// holds the last step, so the next request waits only when a result is still untaken.
// Synchronous active-low reset clears control, configuration and the remembered display.
module head_angle_to_pointer_mapper_top
  import hapm_pkg::*;
#(
  parameter int MAX_DISPLAYS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic signed [14:0]   in_yaw,
  input  logic signed [14:0]   in_pitch,
  input  logic [2:0]           in_entry_index,
  input  logic [3:0]           in_word_select,
  input  logic signed [31:0]   in_word_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_pointer_x,
  output logic [15:0]          out_pointer_y,
  output logic                 out_on_screen,
  output logic [2:0]           out_screen_used,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  hapm_cmd_t cmd;
  hapm_sts_t sts;

  assign cfg_ready = 1'b1;

  hapm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hapm_datapath #(
    .MAX_DISPLAYS (MAX_DISPLAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_yaw          (in_yaw),
    .in_pitch        (in_pitch),
    .in_entry_index  (in_entry_index),
    .in_word_select  (in_word_select),
    .in_word_value   (in_word_value),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_pointer_x   (out_pointer_x),
    .out_pointer_y   (out_pointer_y),
    .out_on_screen   (out_on_screen),
    .out_screen_used (out_screen_used)
  );

endmodule

FILE: rtl/hapm_ctrl.sv
module hapm_ctrl
  import hapm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  hapm_sts_t sts,
  output hapm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FALL,
    S_MUL_X,
    S_ADD_X,
    S_MUL_Y,
    S_ADD_Y
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.n_zero ? S_FALL : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_MUL_X;
        end else if (sts.scan_end) begin
          cmd.fall  = 1'b1;
          state_nxt = S_FALL;
        end else begin
          cmd.next = 1'b1;
        end
      end
      S_FALL: begin
        cmd.decide = 1'b1;
        state_nxt  = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD_X;
      end
      S_ADD_X: begin
        cmd.load_x = 1'b1;
        state_nxt  = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul    = 1'b1;
        cmd.axis_y = 1'b1;
        state_nxt  = S_ADD_Y;
      end
      S_ADD_Y: begin
        cmd.axis_y = 1'b1;
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/hapm_datapath.sv
module hapm_datapath
  import hapm_pkg::*;
#(
  parameter int MAX_DISPLAYS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hapm_cmd_t             cmd,
  output hapm_sts_t             sts,
  input  logic signed [14:0]    in_yaw,
  input  logic signed [14:0]    in_pitch,
  input  logic [2:0]            in_entry_index,
  input  logic [3:0]            in_word_select,
  input  logic signed [31:0]    in_word_value,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [15:0]           out_pointer_x,
  output logic [15:0]           out_pointer_y,
  output logic                  out_on_screen,
  output logic [2:0]            out_screen_used
);

  localparam int IDX_W = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;

  // display table, written by table requests only
  logic [15:0] bound_r  [MAX_DISPLAYS][4];
  logic [23:0] edge_h_r [MAX_DISPLAYS][2];
  logic [23:0] edge_v_r [MAX_DISPLAYS][2];
  logic [31:0] slope_r  [MAX_DISPLAYS][2];
  logic [15:0] pad_r    [MAX_DISPLAYS][4];

  logic [3:0]  count_r;
  logic [31:0] xpp_r, ypp_r;

  logic [IDX_W-1:0]   idx_r, last_r;
  logic signed [14:0] yaw_r, pitch_r;
  axis_mode_t         mode_x_r, mode_y_r;
  logic               on_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [15:0]        px_r;
  logic               out_valid_r;

  logic [4:0]       ent_ext, idx_ext, n_eff;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       pad_sel;

  logic signed [15:0] bl, br, bt, bb, yaw_w, pitch_w;
  logic signed [16:0] dist_x, dist_y;
  axis_mode_t         mode;
  logic [31:0]        mul_a;
  logic signed [16:0] mul_b;
  logic [23:0]        edge_sel;
  logic               do_sub;
  logic signed [SUM_W-1:0] base, sum;
  logic [15:0]        sat;

  assign ent_ext = 5'(in_entry_index);
  assign wr_idx  = ent_ext[IDX_W-1:0];
  assign idx_ext = 5'(idx_r);
  assign pad_sel = 2'(in_word_select - WS_PAD_L);
  assign n_eff   = (5'(count_r) > 5'(MAX_DISPLAYS)) ? 5'(MAX_DISPLAYS) : 5'(count_r);

  assign bl      = bound_r[idx_r][0];
  assign br      = bound_r[idx_r][1];
  assign bt      = bound_r[idx_r][2];
  assign bb      = bound_r[idx_r][3];
  assign yaw_w   = {yaw_r[14], yaw_r};
  assign pitch_w = {pitch_r[14], pitch_r};
  assign dist_x  = {yaw_w[15], yaw_w} - {bl[15], bl};
  assign dist_y  = {bt[15], bt} - {pitch_w[15], pitch_w};

  assign sts.hit      = (yaw_w > bl) && (yaw_w < br) && (pitch_w < bt) && (pitch_w > bb);
  assign sts.scan_end = (idx_ext + 5'd1) >= n_eff;
  assign sts.n_zero   = (n_eff == 5'd0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign mode = cmd.axis_y ? mode_y_r : mode_x_r;

  always_comb begin
    case (mode)
      MODE_PAD_ADD: begin
        mul_a    = cmd.axis_y ? ypp_r : xpp_r;
        mul_b    = {1'b0, (cmd.axis_y ? pad_r[idx_r][2] : pad_r[idx_r][0])};
        edge_sel = cmd.axis_y ? edge_v_r[idx_r][0] : edge_h_r[idx_r][0];
        do_sub   = 1'b0;
      end
      MODE_PAD_SUB: begin
        mul_a    = cmd.axis_y ? ypp_r : xpp_r;
        mul_b    = {1'b0, (cmd.axis_y ? pad_r[idx_r][3] : pad_r[idx_r][1])};
        edge_sel = cmd.axis_y ? edge_v_r[idx_r][1] : edge_h_r[idx_r][1];
        do_sub   = 1'b1;
      end
      default: begin
        mul_a    = cmd.axis_y ? slope_r[idx_r][1] : slope_r[idx_r][0];
        mul_b    = cmd.axis_y ? dist_y : dist_x;
        edge_sel = cmd.axis_y ? edge_v_r[idx_r][0] : edge_h_r[idx_r][0];
        do_sub   = 1'b0;
      end
    endcase
  end

  // edge is Q16.8, product is Q.16
  assign base = $signed({{(SUM_W-32){1'b0}}, edge_sel, 8'd0});
  assign sum  = do_sub ? (base - SUM_W'(prod_r)) : (base + SUM_W'(prod_r));
  assign sat  = sat_pos(sum);

  always_ff @(posedge clk) begin
    // drop writes to entries past the table
    if (cmd.wr && (ent_ext < 5'(MAX_DISPLAYS))) begin
      case (in_word_select) inside
        [WS_BOUND_L:WS_BOUND_B]: bound_r[wr_idx][in_word_select[1:0]] <= in_word_value[15:0];
        [WS_EDGE_HL:WS_EDGE_HR]: edge_h_r[wr_idx][in_word_select[0]] <= in_word_value[23:0];
        [WS_EDGE_VT:WS_EDGE_VB]: edge_v_r[wr_idx][in_word_select[0]] <= in_word_value[23:0];
        [WS_SLOPE_X:WS_SLOPE_Y]: slope_r[wr_idx][in_word_select[0]] <= in_word_value;
        [WS_PAD_L:WS_PAD_B]:     pad_r[wr_idx][pad_sel] <= in_word_value[15:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      yaw_r   <= in_yaw;
      pitch_r <= in_pitch;
    end
    if (cmd.hit) begin
      mode_x_r <= MODE_INTERP;
      mode_y_r <= MODE_INTERP;
      on_r     <= 1'b1;
    end
    if (cmd.decide) begin
      on_r <= 1'b0;
      if (yaw_w < bl) begin
        mode_x_r <= MODE_PAD_ADD;
      end else if (yaw_w > br) begin
        mode_x_r <= MODE_PAD_SUB;
      end else begin
        mode_x_r <= MODE_INTERP;
      end
      if (pitch_w > bt) begin
        mode_y_r <= MODE_PAD_ADD;
      end else if (pitch_w < bb) begin
        mode_y_r <= MODE_PAD_SUB;
      end else begin
        mode_y_r <= MODE_INTERP;
      end
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, mul_a}) * mul_b;
    end
    if (cmd.load_x) begin
      px_r <= sat;
    end
    if (cmd.load_out) begin
      out_pointer_x   <= px_r;
      out_pointer_y   <= sat;
      out_on_screen   <= on_r;
      out_screen_used <= idx_ext[2:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 4'd1;
      xpp_r       <= 32'h0001_0000;
      ypp_r       <= 32'h0001_0000;
      idx_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DISPLAY_COUNT: count_r <= cfg_data[3:0];
          CFG_X_ABS_PER_PIX: xpp_r   <= cfg_data;
          CFG_Y_ABS_PER_PIX: ypp_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        idx_r <= sts.n_zero ? last_r : '0;
      end else if (cmd.next) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.fall) begin
        idx_r <= last_r;
      end
      if (cmd.hit) begin
        last_r <= idx_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/hapm_checker.sv
`include "head_angle_to_pointer_mapper_top_assert.svh"

module hapm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [15:0]       out_pointer_x,
  input logic [15:0]       out_pointer_y,
  input logic              out_on_screen,
  input logic [2:0]        out_screen_used
);

  // a stalled result keeps its payload
  `HAPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_pointer_x) && $stable(out_pointer_y)
    && $stable(out_on_screen) && $stable(out_screen_used),
    "result changed while stalled")

  // a sample request occupies the block
  `HAPM_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && !in_func, !in_ready,
    "ready high right after a sample request")

  // a table write makes no result
  `HAPM_ASSERT_NEXT(a_write_no_result, in_valid && in_ready && in_func && !out_valid,
    !out_valid, "result appeared after a table write")

  // a new result only comes out of a busy block
  `HAPM_ASSERT_NOW(a_result_from_work, $rose(out_valid), !$past(in_ready),
    "result rose while block was idle")

endmodule

bind head_angle_to_pointer_mapper_top hapm_checker u_hapm_checker (.*);
